// ===== rtl/core/aes_pkg.sv =====
// AES-128 package: S-box tables, GF(2^8) helpers, round functions and codes.
// Depends on nothing; used by aes_keyexp and aes128_block_cipher.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundsDef = 10;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } aes_op_e;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // GF(2^8) multiply by x, and general multiply, modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // State is 128 bits, byte 0 in bits 127:120; byte i = r + 4c
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift_fwd = t;
  endfunction

  function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = INV_SBOX[get_byte(s, r + 4*((c + 3*r) % 4))];
      end
    end
    sub_shift_inv = t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127 - 32*c -: 32] = {
        xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
        a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
        a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
        xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    end
    mix_fwd = t;
  endfunction

  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127 - 32*c -: 32] = {
        gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
        gf_mul(a0, 8'd9)  ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
        gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)  ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
        gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)  ^ gf_mul(a3, 8'd14)};
    end
    mix_inv = t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/aes_keyexp.sv =====
// AES-128 key schedule unit: one round key per cycle into the round key memory.
// Depends on aes_pkg. Memory is written here and read by the round sequencer.
`timescale 1ns / 1ps
`default_nettype none
module aes_keyexp #(
  parameter int unsigned Rounds = aes_pkg::RoundsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              go_i,
  input  wire logic [127:0]                      key_i,
  input  wire logic [$clog2(Rounds+1)-1:0]       rd_idx_i,
  output logic      [127:0]                      rd_key_o,
  output logic                                   done_o
);
  import aes_pkg::*;

  localparam int unsigned IdxW = $clog2(Rounds + 1);

  logic [127:0] rk_mem [Rounds + 1];
  logic [127:0] cur_q, cur_d;
  logic [7:0]   rc_q, rc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic         run_q, run_d;
  logic         done_q, done_d;
  logic [31:0]  w0, w1, w2, w3, tw;

  // Next round key from the current one
  always_comb begin
    tw = {SBOX[cur_q[23:16]], SBOX[cur_q[15:8]], SBOX[cur_q[7:0]], SBOX[cur_q[31:24]]}
         ^ {rc_q, 24'h0};
    w0 = cur_q[127:96] ^ tw;
    w1 = cur_q[95:64] ^ w0;
    w2 = cur_q[63:32] ^ w1;
    w3 = cur_q[31:0] ^ w2;
  end

  always_comb begin
    cur_d  = cur_q;
    rc_d   = rc_q;
    idx_d  = idx_q;
    run_d  = run_q;
    done_d = done_q;
    if (go_i) begin
      cur_d  = key_i;
      rc_d   = 8'h01;
      idx_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      cur_d = {w0, w1, w2, w3};
      rc_d  = xtime(rc_q);
      idx_d = idx_q + 1'b1;
      if (idx_q == IdxW'(Rounds)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rc_q  <= rc_d;
  end

  // Round key memory, registered read
  always_ff @(posedge clk_i) begin
    if (run_q && !go_i) rk_mem[idx_q] <= cur_q;
    rd_key_o <= rk_mem[rd_idx_i];
  end

  assign done_o = done_q;

  // Never finished while still expanding
  a_done_run : assert property (@(posedge clk_i) disable iff (!rst_ni) !(done_q && run_q))
    else $error("key expansion done and running together");
  a_go_clr : assert property (@(posedge clk_i) disable iff (!rst_ni) go_i |=> !done_q)
    else $error("done not cleared on restart");
  a_idx_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> idx_q <= IdxW'(Rounds))
    else $error("key index out of range");
endmodule
`default_nettype wire

// ===== rtl/core/aes128_block_cipher.sv =====
// AES-128 encrypt/decrypt top level: config port, key schedule and round sequencer.
// Depends on aes_pkg and aes_keyexp.
//
// Usage:
//  - Key: write index 0 (key bytes 0..7) and index 1 (bytes 8..15) on the cfg
//    channel (cfg_valid_i/cfg_ready_o) while idle. Other indexes are ignored.
//  - A transaction starts when start_i is high and busy_o is low; opcode_i 0
//    encrypts, 1 decrypts. busy_o rises the next cycle.
//  - Rounds run one per cycle through a single shared round unit reading one
//    round key per cycle from the round key memory (one read port).
//  - A block passes through the load state, ten rounds in the round state and the
//    done state; done_o holds the result for one cycle. Key expansion runs first
//    on the first block after reset or after any key write. A new block is taken
//    only once the last one is done and busy_o is low.
//  - Reset clears the key to zero and marks the round keys stale; no clearing
//    pass. The receiver cannot stall: done_o is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher #(
  parameter int unsigned Rounds = aes_pkg::RoundsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        opcode_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             done_o,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);
  import aes_pkg::*;

  localparam int unsigned IdxW = $clog2(Rounds + 1);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEXP = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      st_q, st_d;
  logic [63:0]     key_hi_q, key_lo_q;
  logic            ready_q, ready_d;
  logic            op_q;
  logic            op_sel;
  logic [127:0]    blk_q, blk_d;
  logic [127:0]    st_data_q, st_data_d;
  logic [IdxW-1:0] rnd_q, rnd_d;
  logic [IdxW-1:0] rd_idx;
  logic [127:0]    rk;
  logic            kx_go, kx_done;
  logic            done_q;
  logic [127:0]    fwd_t, inv_t;

  aes_keyexp #(.Rounds(Rounds)) u_kexp (
    .clk_i, .rst_ni, .go_i(kx_go), .key_i({key_hi_q, key_lo_q}),
    .rd_idx_i(rd_idx), .rd_key_o(rk), .done_o(kx_done)
  );

  assign cfg_ready_o = 1'b1;

  // Key registers; any write marks round keys stale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
      if (cfg_index_i == CFG_KEY_LOW)  key_lo_q <= cfg_data_i;
    end
  end

  // Opcode of the transaction being loaded: live input while idle
  assign op_sel = (st_q == ST_IDLE) ? opcode_i : op_q;

  // Round key index for the next cycle's read
  always_comb begin
    if (st_d == ST_LOAD) rd_idx = (op_sel == OP_DECRYPT) ? IdxW'(Rounds) : '0;
    else rd_idx = rnd_d;
  end

  // Shared round unit
  always_comb begin
    fwd_t = sub_shift_fwd(st_data_q);
    if (rnd_q != IdxW'(Rounds)) fwd_t = mix_fwd(fwd_t);
    fwd_t = fwd_t ^ rk;
    inv_t = sub_shift_inv(st_data_q) ^ rk;
    if (rnd_q != '0) inv_t = mix_inv(inv_t);
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    ready_d   = ready_q;
    blk_d     = blk_q;
    st_data_d = st_data_q;
    rnd_d     = rnd_q;
    kx_go     = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          blk_d = {block_high_i, block_low_i};
          if (ready_q) st_d = ST_LOAD;
          else begin
            st_d  = ST_KEXP;
            kx_go = 1'b1;
          end
        end
      end
      ST_KEXP: begin
        if (kx_done) begin
          ready_d = 1'b1;
          st_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        st_data_d = blk_q ^ rk;
        rnd_d     = (op_q == OP_DECRYPT) ? IdxW'(Rounds - 1) : IdxW'(1);
        st_d      = ST_RND;
      end
      ST_RND: begin
        if (op_q == OP_DECRYPT) begin
          st_data_d = inv_t;
          if (rnd_q == '0) st_d = ST_DONE;
          else rnd_d = rnd_q - 1'b1;
        end else begin
          st_data_d = fwd_t;
          if (rnd_q == IdxW'(Rounds)) st_d = ST_DONE;
          else rnd_d = rnd_q + 1'b1;
        end
      end
      ST_DONE: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    if (cfg_valid_i && cfg_ready_o) ready_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ready_q <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      st_q    <= st_d;
      ready_q <= ready_d;
      done_q  <= (st_d == ST_DONE);
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q     <= blk_d;
    st_data_q <= st_data_d;
    if (st_q == ST_IDLE) op_q <= opcode_i;
  end

  assign busy_o        = (st_q != ST_IDLE);
  assign done_o        = done_q;
  assign result_high_o = st_data_q[127:64];
  assign result_low_o  = st_data_q[63:0];

  a_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> st_q == ST_DONE)
    else $error("result strobe outside done state");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transaction accepted but not busy");
  a_load_keys : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_LOAD |-> ready_q)
    else $error("rounds started with stale keys");
  a_done_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire

// ===== tb/sv/aes128_cipher_checker.sv =====
// Scoreboard for the AES-128 block cipher: watches the key, block and result ports,
// predicts every block with its own cipher and compares the results in order.
// Depends on aes_pkg for the opcode and key register codes.
`timescale 1ns / 1ps
module aes128_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        opcode_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        done_i,
  input  logic [63:0] result_high_i,
  input  logic [63:0] result_low_i,
  output int          fail_count_o,
  output int          pending_o
);
  import aes_pkg::*;

  logic [7:0]   fwd_box [256];
  logic [7:0]   rev_box [256];
  logic [63:0]  key_hi_q, key_lo_q;
  logic         keys_stale_q;
  logic [127:0] rkey [11];
  logic [127:0] expected_blocks [$];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-boxes built from field inverse plus affine map
  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (x != 0 && gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_box[x] = s;
      rev_box[s] = x[7:0];
    end
  end

  function automatic void expand_keys(input logic [127:0] k);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]}
            ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] s, input bit rev);
    for (int i = 0; i < 16; i++)
      s[127 - 8*i -: 8] = rev ? rev_box[s[127 - 8*i -: 8]] : fwd_box[s[127 - 8*i -: 8]];
    return s;
  endfunction

  // Row r of column c is byte r + 4c; rev shifts rows right
  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input bit rev);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + (rev ? 3 : 1)*r) % 4)) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input bit rev);
    logic [7:0]   coef [4];
    logic [7:0]   o;
    logic [127:0] t;
    if (rev) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        o = 8'h00;
        for (int k = 0; k < 4; k++)
          o ^= gmul(coef[(k - r + 4) % 4], s[127 - 8*(k + 4*c) -: 8]);
        t[127 - 8*(r + 4*c) -: 8] = o;
      end
    return t;
  endfunction

  function automatic logic [127:0] cipher_block(input aes_op_e op, input logic [127:0] b);
    if (op == OP_ENCRYPT) begin
      b ^= rkey[0];
      for (int r = 1; r < 10; r++) b = mix(rotate_rows(subst(b, 0), 0), 0) ^ rkey[r];
      b = rotate_rows(subst(b, 0), 0) ^ rkey[10];
    end else begin
      b ^= rkey[10];
      for (int r = 9; r >= 1; r--) b = mix(subst(rotate_rows(b, 1), 1) ^ rkey[r], 1);
      b = subst(rotate_rows(b, 1), 1) ^ rkey[0];
    end
    return b;
  endfunction

  assign pending_o = expected_blocks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] exp_blk;
    if (!rst_ni) begin
      key_hi_q     <= '0;
      key_lo_q     <= '0;
      keys_stale_q <= 1'b1;
      fail_count_o <= 0;
    end else begin
      // key register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_KEY_HIGH) key_hi_q <= cfg_data_i;
        else key_lo_q <= cfg_data_i;
        keys_stale_q <= 1'b1;
      end
      // block transaction: expand on first use, then predict
      if (start_i && !busy_i) begin
        if (keys_stale_q) begin
          expand_keys({key_hi_q, key_lo_q});
          keys_stale_q <= 1'b0;
        end
        expected_blocks.push_back(cipher_block(aes_op_e'(opcode_i),
                                               {block_high_i, block_low_i}));
      end
      // result strobe
      if (done_i) begin
        if (expected_blocks.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h_%h", result_high_i,
                                          result_low_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (result_high_i !== exp_blk[127:64] || result_low_i !== exp_blk[63:0]) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %h_%h got %h_%h", exp_blk[127:64],
                       exp_blk[63:0], result_high_i, result_low_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/aes128_block_cipher_tb.sv =====
// Testbench top for aes128_block_cipher: clock, reset, key writes and block stimulus.
// Depends on aes_pkg, the block and aes128_cipher_checker, which does all checking.
`timescale 1ns / 1ps
module aes128_block_cipher_tb;
  import aes_pkg::*;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [63:0] cfg_data;
  logic        start, busy, opcode, done;
  logic [63:0] blk_hi, blk_lo, res_hi, res_lo;
  int          fail_count, pending;
  int          idle_pct;

  aes128_block_cipher i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .start_i(start), .busy_o(busy), .opcode_i(opcode),
    .block_high_i(blk_hi), .block_low_i(blk_lo),
    .done_o(done), .result_high_o(res_hi), .result_low_o(res_lo)
  );

  aes128_cipher_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .start_i(start), .busy_i(busy), .opcode_i(opcode),
    .block_high_i(blk_hi), .block_low_i(blk_lo),
    .done_i(done), .result_high_i(res_hi), .result_low_i(res_lo),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random idle cycles before a transaction, at the phase's idle rate
  task automatic idle_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      blk_hi <= rand64();
      n++;
    end
  endtask

  task automatic send_block(input aes_op_e op, input logic [63:0] hi, input logic [63:0] lo);
    idle_gap();
    @(negedge clk);
    start  <= 1'b1;
    opcode <= op;
    blk_hi <= hi;
    blk_lo <= lo;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    start  <= 1'b0;
    opcode <= aes_op_e'($urandom_range(1));
    blk_hi <= rand64();
    blk_lo <= rand64();
  endtask

  // Let the block drain completely before touching the key
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_key_reg(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= rand64();
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    settle();
    write_key_reg(CFG_KEY_HIGH, hi);
    write_key_reg(CFG_KEY_LOW, lo);
  endtask

  task automatic random_blocks(input int count, input logic [63:0] key_hi,
                               input logic [63:0] key_lo);
    logic [63:0] hi, lo;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin hi = '0; lo = '1; end
        1: begin hi = '1; lo = '0; end
        2: begin hi = key_hi; lo = key_lo; end
        default: begin hi = rand64(); lo = rand64(); end
      endcase
      send_block(aes_op_e'($urandom_range(1)), hi, lo);
    end
  endtask

  initial begin
    logic [63:0] khi, klo;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    start     = 1'b0;
    opcode    = 1'b0;
    blk_hi    = '0;
    blk_lo    = '0;
    idle_pct  = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // blocks before any key write use the all-zero key
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);

    // standard test key and vector, then decrypt its ciphertext
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_DECRYPT, '1, '0);

    // all-ones key with extreme blocks
    load_key('1, '1);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);

    // only one half rewritten: still forces re-expansion
    settle();
    write_key_reg(CFG_KEY_LOW, '0);
    send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);

    // random phases: each with a fresh key and its own idle rate
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 37;
      endcase
      khi = rand64();
      klo = rand64();
      if (ph == 3) khi = '0;
      if (ph == 5) klo = '1;
      load_key(khi, klo);
      random_blocks(100, khi, klo);
    end

    // drain, then let the core go quiet
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
